/* design/hcmbd_pkg.sv */
// Types and constants for the handheld console memory bus decoder.
package hcmbd_pkg;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_FLAGS = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    RGN_NONE,
    RGN_ROM,
    RGN_WORK,
    RGN_IO,
    RGN_HIGH,
    RGN_DIV,
    RGN_CNT,
    RGN_FLAG,
    RGN_ENABLE
  } region_e;

  localparam logic [15:0] ADDR_SERIAL_DATA = 16'hFF01;
  localparam logic [15:0] ADDR_SERIAL_CTRL = 16'hFF02;
  localparam logic [15:0] ADDR_DIV         = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA        = 16'hFF05;
  localparam logic [15:0] ADDR_TMA         = 16'hFF06;
  localparam logic [15:0] ADDR_TAC         = 16'hFF07;
  localparam logic [15:0] ADDR_IF          = 16'hFF0F;
  localparam logic [15:0] ADDR_IE          = 16'hFFFF;
  localparam logic [15:0] ECHO_LO          = 16'hE000;
  localparam logic [15:0] ECHO_HI          = 16'hFDFF;
  localparam logic [15:0] ECHO_OFFSET      = 16'h2000;
  localparam logic [15:0] WORK_LO          = 16'hC000;
  localparam logic [15:0] WORK_HI          = 16'hDFFF;
  localparam logic [15:0] IO_LO            = 16'hFF00;
  localparam logic [15:0] IO_HI            = 16'hFF7F;
  localparam logic [15:0] HIGH_LO          = 16'hFF80;
  localparam logic [15:0] HIGH_HI          = 16'hFFFE;
  localparam logic [7:0]  SERIAL_START     = 8'h81;
  localparam logic [7:0]  FLAG_MASK        = 8'h1F;

  localparam int IO_BYTES   = 128;
  localparam int HIGH_BYTES = 127;
  localparam int IO_AW      = $clog2(IO_BYTES);
  localparam int HIGH_AW    = $clog2(HIGH_BYTES);

  typedef struct packed {
    action_e     action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  divider_value;
    logic [7:0]  counter_value;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [4:0] interrupt_flags;
    logic [7:0] interrupt_enable;
    logic       serial_valid;
    logic [7:0] serial_byte;
    logic       divider_reset;
    logic       counter_load;
    logic [7:0] counter_load_value;
    logic       timer_settings_valid;
    logic       timer_enable;
    logic [1:0] timer_rate_select;
    logic [7:0] timer_modulo;
  } out_t;

  // Fold the echo window onto work RAM.
  function automatic logic [15:0] unecho(input logic [15:0] a);
    logic [15:0] m;
    m = a;
    if (a >= ECHO_LO && a <= ECHO_HI) m = a - ECHO_OFFSET;
    return m;
  endfunction

  function automatic region_e read_region(input logic [15:0] a);
    logic [15:0] m;
    region_e     r;
    m = unecho(a);
    priority if (!a[15])                    r = RGN_ROM;
    else if (m >= WORK_LO && m <= WORK_HI)  r = RGN_WORK;
    else if (a == ADDR_DIV)                 r = RGN_DIV;
    else if (a == ADDR_TIMA)                r = RGN_CNT;
    else if (a == ADDR_IF)                  r = RGN_FLAG;
    else if (a == ADDR_IE)                  r = RGN_ENABLE;
    else if (a >= IO_LO && a <= IO_HI)      r = RGN_IO;
    else if (a >= HIGH_LO && a <= HIGH_HI)  r = RGN_HIGH;
    else                                    r = RGN_NONE;
    return r;
  endfunction

endpackage

/* design/handheld_console_memory_bus_decoder_unit.sv */
// Memory bus decoder: ROM, work RAM, I/O, high RAM and interrupt registers.
//
// Each transaction is one bus action (read, write, ROM load, interrupt flag
// update). Its result passes through one access stage, then the result register.
// A new transaction is accepted every cycle unless the result side stalls;
// the rate is set by the single synchronous port of each memory (ROM, work
// RAM, high RAM, I/O), which is read or written once per transaction, with
// the read data registered and the byte selection done in the next cycle.
// ROM, work RAM and high RAM hold no reset value and must be written before
// they are read. The I/O store reads as zero after reset through one valid
// bit per byte, so no clearing pass is needed and the block is ready at once.
module handheld_console_memory_bus_decoder_unit import hcmbd_pkg::*; #(
  parameter int ROM_BYTES  = 32768,
  parameter int WORK_BYTES = 8192
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int ROM_AW  = $clog2(ROM_BYTES);
  localparam int WORK_AW = $clog2(WORK_BYTES);

  // Decode info carried from the memory access stage to the result stage.
  typedef struct packed {
    region_e    region;
    logic [7:0] divider_value;
    logic [7:0] counter_value;
    logic       serial_valid;
    logic       divider_reset;
    logic       counter_load;
    logic [7:0] counter_load_value;
    logic       timer_settings_valid;
  } stage_t;

  logic out_valid_q;
  logic advance, accept;
  assign advance    = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && advance;
  assign in_stall_o = !advance;

  logic [15:0] addr, maddr;
  logic [7:0]  wdata;
  assign addr  = in_data_i.address;
  assign wdata = in_data_i.write_data;
  assign maddr = unecho(addr);

  logic is_write, plain_write;
  assign is_write    = in_data_i.action == ACT_WRITE;
  assign plain_write = is_write && addr != ADDR_SERIAL_DATA && addr != ADDR_SERIAL_CTRL &&
                       addr != ADDR_DIV && addr != ADDR_TIMA && addr != ADDR_IF &&
                       addr != ADDR_IE;

  logic rom_we, work_we, io_we, high_we, serial_we, flag_we, enable_we;
  logic [WORK_AW-1:0] work_idx;
  assign work_idx  = maddr[WORK_AW-1:0];
  assign rom_we    = accept && in_data_i.action == ACT_LOAD && 32'(addr) < ROM_BYTES;
  assign work_we   = accept && plain_write && maddr >= WORK_LO && maddr <= WORK_HI &&
                     32'(work_idx) < WORK_BYTES;
  assign io_we     = accept && plain_write && addr >= IO_LO && addr <= IO_HI;
  assign high_we   = accept && plain_write && addr >= HIGH_LO && addr <= HIGH_HI;
  assign serial_we = accept && is_write && addr == ADDR_SERIAL_DATA;
  assign flag_we   = accept && (in_data_i.action == ACT_FLAGS || (is_write && addr == ADDR_IF));
  assign enable_we = accept && is_write && addr == ADDR_IE;

  // Memories: one address per transaction, read data held while stalled.
  logic [7:0] rom_mem  [ROM_BYTES];
  logic [7:0] work_mem [WORK_BYTES];
  logic [7:0] high_mem [HIGH_BYTES];
  logic [7:0] io_mem   [IO_BYTES];
  logic [7:0] rom_rd_q, work_rd_q, high_rd_q, io_rd_q;

  always_ff @(posedge clk_i) begin
    if (rom_we) rom_mem[addr[ROM_AW-1:0]] <= wdata;
    if (advance) rom_rd_q <= rom_mem[addr[ROM_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) work_mem[work_idx] <= wdata;
    if (advance) work_rd_q <= work_mem[work_idx];
  end

  always_ff @(posedge clk_i) begin
    if (high_we) high_mem[addr[HIGH_AW-1:0]] <= wdata;
    if (advance) high_rd_q <= high_mem[addr[HIGH_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (io_we) io_mem[addr[IO_AW-1:0]] <= wdata;
    if (advance) io_rd_q <= io_mem[addr[IO_AW-1:0]];
  end

  logic [IO_BYTES-1:0] io_vld_q;
  logic                io_vld_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      io_vld_q    <= '0;
      io_vld_rd_q <= 1'b0;
    end else begin
      if (io_we) io_vld_q[addr[IO_AW-1:0]] <= 1'b1;
      if (advance) io_vld_rd_q <= io_vld_q[addr[IO_AW-1:0]];
    end
  end

  // Architectural registers, updated at acceptance.
  logic [4:0] flag_q;
  logic [7:0] enable_q, serial_q, tma_q;
  logic [2:0] tac_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q   <= '0;
      enable_q <= '0;
      serial_q <= '0;
      tma_q    <= '0;
      tac_q    <= '0;
    end else begin
      if (flag_we)   flag_q   <= 5'(wdata & FLAG_MASK);
      if (enable_we) enable_q <= wdata;
      if (serial_we) serial_q <= wdata;
      if (io_we && addr == ADDR_TMA) tma_q <= wdata;
      if (io_we && addr == ADDR_TAC) tac_q <= wdata[2:0];
    end
  end

  stage_t stage_d, stage_q;
  logic   stage_valid_q;
  always_comb begin
    stage_d.region = (in_data_i.action == ACT_READ) ? read_region(addr) : RGN_NONE;
    stage_d.divider_value        = in_data_i.divider_value;
    stage_d.counter_value        = in_data_i.counter_value;
    stage_d.serial_valid         = is_write && addr == ADDR_SERIAL_CTRL && wdata == SERIAL_START;
    stage_d.divider_reset        = is_write && addr == ADDR_DIV;
    stage_d.counter_load         = is_write && addr == ADDR_TIMA;
    stage_d.counter_load_value   = (is_write && addr == ADDR_TIMA) ? wdata : 8'd0;
    stage_d.timer_settings_valid = plain_write && (addr == ADDR_TMA || addr == ADDR_TAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (advance) begin
      stage_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) stage_q <= stage_d;
  end

  // Result stage: pick the byte and attach register state.
  out_t out_d, out_q;
  always_comb begin
    unique case (stage_q.region)
      RGN_ROM:    out_d.read_data = rom_rd_q;
      RGN_WORK:   out_d.read_data = work_rd_q;
      RGN_IO:     out_d.read_data = io_vld_rd_q ? io_rd_q : 8'd0;
      RGN_HIGH:   out_d.read_data = high_rd_q;
      RGN_DIV:    out_d.read_data = stage_q.divider_value;
      RGN_CNT:    out_d.read_data = stage_q.counter_value;
      RGN_FLAG:   out_d.read_data = {3'd0, flag_q};
      RGN_ENABLE: out_d.read_data = enable_q;
      default:    out_d.read_data = 8'd0;
    endcase
    out_d.interrupt_flags      = flag_q;
    out_d.interrupt_enable     = enable_q;
    out_d.serial_valid         = stage_q.serial_valid;
    out_d.serial_byte          = stage_q.serial_valid ? serial_q : 8'd0;
    out_d.divider_reset        = stage_q.divider_reset;
    out_d.counter_load         = stage_q.counter_load;
    out_d.counter_load_value   = stage_q.counter_load_value;
    out_d.timer_settings_valid = stage_q.timer_settings_valid;
    out_d.timer_enable         = stage_q.timer_settings_valid ? tac_q[2] : 1'b0;
    out_d.timer_rate_select    = stage_q.timer_settings_valid ? tac_q[1:0] : 2'd0;
    out_d.timer_modulo         = stage_q.timer_settings_valid ? tma_q : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= stage_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && stage_valid_q) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // At most one strobe per transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.serial_valid, out_data_o.divider_reset,
                              out_data_o.counter_load, out_data_o.timer_settings_valid}))
    else $error("more than one strobe in one result");

  // A read never raises a strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_data != 8'd0 |->
      !out_data_o.serial_valid && !out_data_o.divider_reset &&
      !out_data_o.counter_load && !out_data_o.timer_settings_valid)
    else $error("read data together with a write strobe");

  // An accepted transaction reaches the access stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> stage_valid_q)
    else $error("accepted transaction lost before the access stage");

endmodule
